[hdl/arp_cache_responder_defines.svh]
// assertion macros for the arp cache responder
// no dependencies
`ifndef ARP_CACHE_RESPONDER_DEFINES_SVH
`define ARP_CACHE_RESPONDER_DEFINES_SVH
// property that holds after reset
`define ACR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// implication that holds after reset
`define ACR_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);
`endif

[hdl/acr_pkg.sv]
// shared types and constants for the arp cache responder
// no dependencies
package acr_pkg;
  localparam int CacheEntries = 16;
  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [2:0] ST_NONE = 3'd0;
  localparam logic [2:0] ST_REPLY = 3'd1;
  localparam logic [2:0] ST_BADFMT = 3'd2;
  localparam logic [2:0] ST_UNKCODE = 3'd3;
  localparam logic [2:0] ST_HIT = 3'd4;
  localparam logic [2:0] ST_MISS = 3'd5;
  localparam logic [15:0] HW_ETHER = 16'h0001;
  localparam logic [15:0] PROTO_IPV4 = 16'h0800;
  localparam logic [7:0] HW_SIZE = 8'd6;
  localparam logic [7:0] PROTO_SIZE = 8'd4;
  localparam logic [15:0] CODE_REQ = 16'd1;
  localparam logic [15:0] CODE_RSP = 16'd2;
  localparam logic [47:0] BCAST_MAC = 48'hffff_ffff_ffff;
  localparam logic [2:0] CFG_OWN_MAC = 3'd0;
  localparam logic [2:0] CFG_OWN_IP = 3'd1;
  localparam logic [2:0] CFG_SUB_BASE = 3'd2;
  localparam logic [2:0] CFG_SUB_MASK = 3'd3;
  localparam logic [2:0] CFG_LIFETIME = 3'd4;

  // classified job handed from front to back
  typedef enum logic [2:0] {
    JOB_FRAME  = 3'b001,
    JOB_LOOKUP = 3'b010,
    JOB_NONE   = 3'b100
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic        bad_fmt;
    logic [15:0] code;
    logic [47:0] mac;
    logic [31:0] sip;
    logic [31:0] tip;
  } job_t;
endpackage

[hdl/arp_cache_responder.sv]
// top level of the arp cache responder with ttl and proxy reply
// depends on acr_pkg, acr_front, acr_queue, acr_back and the defines header
//
// Usage: raise start with the item on the in_ ports; the item is a transfer at a
// clock edge where start is high and busy is low. op 0 is a received ARP frame,
// op 1 an IP lookup, op 2 a time tick. Every item gives one result, marked by
// out_valid for a single cycle; the receiver cannot stall it.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// must write it only while the block is idle. The block itself does not enforce this.
// Scanning: frames and lookups scan the cache one slot per cycle, and a good
// frame then passes through a write state before its result. Bad frames and
// ticks skip the scan. The back end takes one item at a time, so the cache
// scan sets the throughput.
// A two-entry queue lets the front take items while the back scans; busy is
// high when it is full.
// Reset (synchronous, rst_n low) empties the cache through per-slot valid
// bits at once, clears the time counter and queue, and loads lifetime 30.
`include "arp_cache_responder_defines.svh"
module arp_cache_responder import acr_pkg::*; #(
  parameter int CACHE_ENTRIES = CacheEntries
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_hw_type,
  input  logic [15:0] in_proto_type,
  input  logic [7:0]  in_hw_len,
  input  logic [7:0]  in_proto_len,
  input  logic [15:0] in_arp_code,
  input  logic [47:0] in_src_mac,
  input  logic [31:0] in_src_ip,
  input  logic [31:0] in_dst_ip,
  input  logic [31:0] in_lookup_ip,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic        out_send_frame,
  output logic [47:0] out_frame_dst_mac,
  output logic [1:0]  out_frame_code,
  output logic [47:0] out_frame_sender_mac,
  output logic [31:0] out_frame_sender_ip,
  output logic [47:0] out_frame_target_mac,
  output logic [31:0] out_frame_target_ip,
  output logic [47:0] out_found_mac,
  output logic        out_store_failed
);
  logic [47:0] own_mac_r;
  logic [31:0] own_ip_r, sub_base_r, sub_mask_r;
  logic [15:0] lifetime_r;
  logic        q_push, q_full, q_pop, q_avail, scanning;
  job_t        push_job, head_job;
  logic [31:0] time_now, head_time;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r <= '0;
      own_ip_r <= '0;
      sub_base_r <= '0;
      sub_mask_r <= '0;
      lifetime_r <= 16'd30;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_MAC: own_mac_r <= cfg_data;
        CFG_OWN_IP: own_ip_r <= cfg_data[31:0];
        CFG_SUB_BASE: sub_base_r <= cfg_data[31:0];
        CFG_SUB_MASK: sub_mask_r <= cfg_data[31:0];
        CFG_LIFETIME: lifetime_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  acr_front u_front (
    .clk, .rst_n, .start, .busy,
    .in_op, .in_hw_type, .in_proto_type, .in_hw_len, .in_proto_len,
    .in_arp_code, .in_src_mac, .in_src_ip, .in_dst_ip, .in_lookup_ip,
    .q_full, .q_push, .q_job(push_job), .time_now
  );

  acr_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_job, .push_time(time_now), .full(q_full),
    .pop(q_pop), .avail(q_avail), .head_job, .head_time
  );

  acr_back #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_back (
    .clk, .rst_n, .q_avail, .q_job(head_job), .q_time(head_time), .q_pop,
    .own_mac(own_mac_r), .own_ip(own_ip_r), .subnet_base(sub_base_r),
    .net_mask(sub_mask_r), .entry_lifetime(lifetime_r),
    .out_valid, .out_status, .out_send_frame, .out_frame_dst_mac, .out_frame_code,
    .out_frame_sender_mac, .out_frame_sender_ip, .out_frame_target_mac,
    .out_frame_target_ip, .out_found_mac, .out_store_failed, .scanning
  );

  // checks
  `ACR_IMPLY(a_frame_fields, out_valid && !out_send_frame, out_frame_dst_mac == '0, "frame set")
  `ACR_IMPLY(a_pop_idle, q_pop, q_avail && !scanning, "pop from empty queue or busy back end")
  `ACR_IMPLY(a_hit_no_send, out_valid && out_status == ST_HIT, !out_send_frame, "hit with a frame")
endmodule

[hdl/acr_front.sv]
// front end: accepts items, checks frame format, runs the tick counter
// depends on acr_pkg
module acr_front import acr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_hw_type,
  input  logic [15:0] in_proto_type,
  input  logic [7:0]  in_hw_len,
  input  logic [7:0]  in_proto_len,
  input  logic [15:0] in_arp_code,
  input  logic [47:0] in_src_mac,
  input  logic [31:0] in_src_ip,
  input  logic [31:0] in_dst_ip,
  input  logic [31:0] in_lookup_ip,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job,
  output logic [31:0] time_now
);
  logic [31:0] time_r, time_nxt;
  logic        take;

  assign busy = q_full;
  assign take = start && !q_full;
  assign time_now = time_r;

  // classify the transfer
  always_comb begin
    q_job.code = in_arp_code;
    q_job.mac = in_src_mac;
    q_job.sip = in_src_ip;
    q_job.tip = in_dst_ip;
    q_job.bad_fmt = (in_hw_type != HW_ETHER) || (in_proto_type != PROTO_IPV4) ||
                    (in_hw_len != HW_SIZE) || (in_proto_len != PROTO_SIZE);
    unique case (in_op)
      OP_FRAME: q_job.kind = JOB_FRAME;
      OP_LOOKUP: begin
        q_job.kind = JOB_LOOKUP;
        q_job.tip = in_lookup_ip;
      end
      default: q_job.kind = JOB_NONE;
    endcase
  end
  assign q_push = take;

  // saturating tick counter, applied at accept since items run in order
  always_comb begin
    time_nxt = time_r;
    if (take && in_op == OP_TICK && time_r != 32'hffff_ffff) time_nxt = time_r + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) time_r <= '0;
    else time_r <= time_nxt;
  end
endmodule

[hdl/acr_queue.sv]
// two-entry queue between front and back
// depends on acr_pkg
module acr_queue import acr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic [31:0] push_time,
  output logic full,
  input  logic pop,
  output logic avail,
  output job_t head_job,
  output logic [31:0] head_time
);
  job_t        job_r [2];
  logic [31:0] tm_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign full = cnt_r == 2'd2;
  assign avail = cnt_r != 2'd0;
  assign head_job = job_r[rp_r];
  assign head_time = tm_r[rp_r];

  // pointer and count update
  always_comb begin
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      job_r[wp_r] <= push_job;
      tm_r[wp_r] <= push_time;
    end
  end
endmodule

[hdl/acr_back.sv]
// back end: scans the cache one slot a cycle, stores senders, forms results
// depends on acr_pkg
module acr_back import acr_pkg::*; #(
  parameter int CACHE_ENTRIES = CacheEntries
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_avail,
  input  job_t        q_job,
  input  logic [31:0] q_time,
  output logic        q_pop,
  input  logic [47:0] own_mac,
  input  logic [31:0] own_ip,
  input  logic [31:0] subnet_base,
  input  logic [31:0] net_mask,
  input  logic [15:0] entry_lifetime,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic        out_send_frame,
  output logic [47:0] out_frame_dst_mac,
  output logic [1:0]  out_frame_code,
  output logic [47:0] out_frame_sender_mac,
  output logic [31:0] out_frame_sender_ip,
  output logic [47:0] out_frame_target_mac,
  output logic [31:0] out_frame_target_ip,
  output logic [47:0] out_found_mac,
  output logic        out_store_failed,
  output logic        scanning
);
  localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CW = $clog2(CACHE_ENTRIES + 1);
  localparam logic [CW-1:0] LAST = CW'(CACHE_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  logic [31:0] ip_r [CACHE_ENTRIES];
  logic [47:0] mac_r [CACHE_ENTRIES];
  logic [31:0] exp_r [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] vld_r;

  state_t      st_r, st_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  job_t        job_r;
  logic [31:0] now_r;
  logic        live_r, live_nxt, slot_r, slot_nxt;
  logic [IW-1:0] slot_idx_r, slot_idx_nxt;
  logic [47:0] hit_mac_r, hit_mac_nxt;

  logic        rd_vld_r;
  logic [31:0] rd_ip_r, rd_exp_r;
  logic [47:0] rd_mac_r;
  logic [31:0] rd_ip, rd_exp;
  logic [47:0] rd_mac;
  logic [32:0] exp_sum;
  logic [31:0] exp_new;
  logic        is_frame, do_store, want_reply, take_slot;

  assign scanning = st_r != S_IDLE;
  assign is_frame = job_r.kind == JOB_FRAME;
  assign do_store = is_frame && !job_r.bad_fmt;

  // registered read of the next slot to scan
  always_ff @(posedge clk) begin
    rd_vld_r <= vld_r[idx_nxt[IW-1:0]];
    rd_ip_r <= ip_r[idx_nxt[IW-1:0]];
    rd_exp_r <= exp_r[idx_nxt[IW-1:0]];
    rd_mac_r <= mac_r[idx_nxt[IW-1:0]];
  end

  // invalid slots read as zero
  always_comb begin
    rd_ip = rd_vld_r ? rd_ip_r : '0;
    rd_exp = rd_vld_r ? rd_exp_r : '0;
    rd_mac = rd_vld_r ? rd_mac_r : '0;
  end

  assign exp_sum = {1'b0, now_r} + {17'd0, entry_lifetime};
  assign exp_new = exp_sum[32] ? 32'hffff_ffff : exp_sum[31:0];

  // first reusable slot in scan order
  assign take_slot = !slot_r && (rd_ip == 32'd0 || rd_ip == job_r.sip || rd_exp < now_r);

  assign want_reply = job_r.code == CODE_REQ &&
                      (job_r.tip & net_mask) == subnet_base &&
                      job_r.tip != job_r.sip && job_r.sip != 32'd0 && !live_r;

  // sequencer
  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    live_nxt = live_r;
    slot_nxt = slot_r;
    slot_idx_nxt = slot_idx_r;
    hit_mac_nxt = hit_mac_r;
    q_pop = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (q_avail) begin
          q_pop = 1'b1;
          idx_nxt = '0;
          live_nxt = 1'b0;
          slot_nxt = 1'b0;
          hit_mac_nxt = '0;
          if (q_job.kind == JOB_NONE || (q_job.kind == JOB_FRAME && q_job.bad_fmt))
            st_nxt = S_DONE;
          else st_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // live check sees the cache after the store: the slot a frame overwrites is skipped
        if (!live_r && rd_ip == job_r.tip && rd_exp > now_r && !(is_frame && take_slot)) begin
          live_nxt = 1'b1;
          hit_mac_nxt = rd_mac;
        end
        if (take_slot) begin
          slot_nxt = 1'b1;
          slot_idx_nxt = idx_r[IW-1:0];
        end
        if (idx_r == LAST) st_nxt = is_frame ? S_WRITE : S_DONE;
        else idx_nxt = idx_r + CW'(1);
      end
      S_WRITE: st_nxt = S_DONE;
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      vld_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_WRITE && slot_r) vld_r[slot_idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    live_r <= live_nxt;
    slot_r <= slot_nxt;
    slot_idx_r <= slot_idx_nxt;
    hit_mac_r <= hit_mac_nxt;
    if (st_r == S_IDLE && q_avail) begin
      job_r <= q_job;
      now_r <= q_time;
    end
    if (st_r == S_WRITE && slot_r) begin
      ip_r[slot_idx_r] <= job_r.sip;
      mac_r[slot_idx_r] <= job_r.mac;
      exp_r[slot_idx_r] <= exp_new;
    end
  end

  // result strobe and fields
  always_comb begin
    out_valid = st_r == S_DONE;
    out_status = ST_NONE;
    out_send_frame = 1'b0;
    out_frame_dst_mac = '0;
    out_frame_code = '0;
    out_frame_sender_mac = '0;
    out_frame_sender_ip = '0;
    out_frame_target_mac = '0;
    out_frame_target_ip = '0;
    out_found_mac = '0;
    out_store_failed = do_store && !slot_r;
    priority if (is_frame && job_r.bad_fmt) begin
      out_status = ST_BADFMT;
    end else if (is_frame) begin
      if (job_r.code == CODE_REQ) begin
        if (want_reply) begin
          out_status = ST_REPLY;
          out_send_frame = 1'b1;
          out_frame_dst_mac = job_r.mac;
          out_frame_code = CODE_RSP[1:0];
          out_frame_sender_mac = own_mac;
          out_frame_sender_ip = job_r.tip;
          out_frame_target_mac = job_r.mac;
          out_frame_target_ip = job_r.sip;
        end
      end else if (job_r.code != CODE_RSP) begin
        out_status = ST_UNKCODE;
      end
    end else if (job_r.kind == JOB_LOOKUP) begin
      if (live_r) begin
        out_status = ST_HIT;
        out_found_mac = hit_mac_r;
      end else begin
        out_status = ST_MISS;
        out_send_frame = 1'b1;
        out_frame_dst_mac = BCAST_MAC;
        out_frame_code = CODE_REQ[1:0];
        out_frame_sender_mac = own_mac;
        out_frame_sender_ip = own_ip;
        out_frame_target_ip = job_r.tip;
      end
    end else begin
      out_status = ST_NONE;
    end
  end
endmodule

[tb/tb_arp_cache_responder.sv]
// self-checking testbench for the arp cache responder: directed table, then random traffic
// depends on acr_pkg and arp_cache_responder; a local cache predictor supplies expectations
`timescale 1ns / 100ps
module tb_arp_cache_responder;
  import acr_pkg::*;

  localparam int WatchLimit = 3000;
  localparam int ChunkItems = 225;
  localparam int NumChunks = 6;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] arp_code;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [31:0] lookup_ip;
  } arp_item_t;

  typedef struct {
    logic [2:0]  status;
    logic        send_frame;
    logic [47:0] dst_mac;
    logic [1:0]  code;
    logic [47:0] snd_mac;
    logic [31:0] snd_ip;
    logic [47:0] tgt_mac;
    logic [31:0] tgt_ip;
    logic [47:0] found_mac;
    logic        store_failed;
  } arp_result_t;

  typedef struct {
    arp_item_t   item;
    bit          typed;
    arp_result_t res;
  } dir_row_t;

  logic clk, rst_n, start, busy;
  logic [1:0]  in_op;
  logic [15:0] in_hw_type, in_proto_type, in_arp_code;
  logic [7:0]  in_hw_len, in_proto_len;
  logic [47:0] in_src_mac;
  logic [31:0] in_src_ip, in_dst_ip, in_lookup_ip;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;
  logic        out_valid, out_send_frame, out_store_failed;
  logic [2:0]  out_status;
  logic [1:0]  out_frame_code;
  logic [47:0] out_frame_dst_mac, out_frame_sender_mac, out_frame_target_mac, out_found_mac;
  logic [31:0] out_frame_sender_ip, out_frame_target_ip;

  arp_cache_responder DUT (.*);

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // predictor state
  logic [47:0] m_own_mac;
  logic [31:0] m_own_ip, m_sub_base, m_sub_mask;
  logic [15:0] m_lifetime;
  logic [31:0] c_ip [CacheEntries];
  logic [47:0] c_mac [CacheEntries];
  logic [31:0] c_expiry [CacheEntries];
  logic [31:0] now_ticks;

  arp_result_t pending_q[$];
  dir_row_t    dir_rows[$];
  int errors = 0, items_sent = 0, results_seen = 0, replies = 0, hits = 0, fails_seen = 0;
  int idle_cycles = 0;
  int sender_pct = 0;

  function automatic int find_live(input logic [31:0] ip);
    for (int i = 0; i < CacheEntries; i++)
      if (c_ip[i] == ip && c_expiry[i] > now_ticks) return i;
    return -1;
  endfunction

  function automatic bit cache_store(input logic [31:0] ip, input logic [47:0] mac);
    logic [32:0] sum;
    for (int i = 0; i < CacheEntries; i++) begin
      if (c_ip[i] == 32'd0 || c_ip[i] == ip || c_expiry[i] < now_ticks) begin
        sum = {1'b0, now_ticks} + {17'd0, m_lifetime};
        c_ip[i] = ip;
        c_mac[i] = mac;
        c_expiry[i] = sum[32] ? 32'hffff_ffff : sum[31:0];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // cache and responder behavior for one accepted item
  function automatic arp_result_t arp_predict(input arp_item_t it);
    arp_result_t r;
    int k;
    r = '{default: '0};
    case (it.op)
      OP_FRAME: begin
        if (it.hw_type != HW_ETHER || it.proto_type != PROTO_IPV4 ||
            it.hw_len != HW_SIZE || it.proto_len != PROTO_SIZE) begin
          r.status = ST_BADFMT;
        end else begin
          r.store_failed = !cache_store(it.src_ip, it.src_mac);
          if (it.arp_code == CODE_REQ) begin
            if ((it.dst_ip & m_sub_mask) == m_sub_base && it.dst_ip != it.src_ip &&
                it.src_ip != 32'd0 && find_live(it.dst_ip) < 0) begin
              r.status = ST_REPLY;
              r.send_frame = 1'b1;
              r.dst_mac = it.src_mac;
              r.code = CODE_RSP[1:0];
              r.snd_mac = m_own_mac;
              r.snd_ip = it.dst_ip;
              r.tgt_mac = it.src_mac;
              r.tgt_ip = it.src_ip;
            end else begin
              r.status = ST_NONE;
            end
          end else if (it.arp_code == CODE_RSP) begin
            r.status = ST_NONE;
          end else begin
            r.status = ST_UNKCODE;
          end
        end
      end
      OP_LOOKUP: begin
        k = find_live(it.lookup_ip);
        if (k >= 0) begin
          r.status = ST_HIT;
          r.found_mac = c_mac[k];
        end else begin
          r.status = ST_MISS;
          r.send_frame = 1'b1;
          r.dst_mac = BCAST_MAC;
          r.code = CODE_REQ[1:0];
          r.snd_mac = m_own_mac;
          r.snd_ip = m_own_ip;
          r.tgt_ip = it.lookup_ip;
        end
      end
      OP_TICK: if (now_ticks != 32'hffff_ffff) now_ticks++;
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [47:0] got,
                                 input logic [47:0] want);
    errors++;
    $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
  endtask

  // result checking
  always @(posedge clk) begin
    arp_result_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("unexpected result at %0t", $realtime);
      end else begin
        e = pending_q.pop_front();
        if (out_status !== e.status) report_mismatch("status", out_status, e.status);
        if (out_send_frame !== e.send_frame)
          report_mismatch("send_frame", out_send_frame, e.send_frame);
        if (out_frame_dst_mac !== e.dst_mac)
          report_mismatch("frame_dst_mac", out_frame_dst_mac, e.dst_mac);
        if (out_frame_code !== e.code) report_mismatch("frame_code", out_frame_code, e.code);
        if (out_frame_sender_mac !== e.snd_mac)
          report_mismatch("frame_sender_mac", out_frame_sender_mac, e.snd_mac);
        if (out_frame_sender_ip !== e.snd_ip)
          report_mismatch("frame_sender_ip", out_frame_sender_ip, e.snd_ip);
        if (out_frame_target_mac !== e.tgt_mac)
          report_mismatch("frame_target_mac", out_frame_target_mac, e.tgt_mac);
        if (out_frame_target_ip !== e.tgt_ip)
          report_mismatch("frame_target_ip", out_frame_target_ip, e.tgt_ip);
        if (out_found_mac !== e.found_mac)
          report_mismatch("found_mac", out_found_mac, e.found_mac);
        if (out_store_failed !== e.store_failed)
          report_mismatch("store_failed", out_store_failed, e.store_failed);
        if (e.status == ST_REPLY) replies++;
        if (e.status == ST_HIT) hits++;
        if (e.store_failed) fails_seen++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("** arp_cache_responder: FAILED **");
      $finish;
    end
  end

  function automatic arp_item_t mk_frame(input logic [15:0] code, input logic [47:0] mac,
                                         input logic [31:0] sip, input logic [31:0] tip);
    arp_item_t it;
    it = '{op: OP_FRAME, hw_type: HW_ETHER, proto_type: PROTO_IPV4, hw_len: HW_SIZE,
           proto_len: PROTO_SIZE, arp_code: code, src_mac: mac, src_ip: sip, dst_ip: tip,
           lookup_ip: 32'd0};
    return it;
  endfunction

  function automatic arp_item_t mk_op(input logic [1:0] op, input logic [31:0] ip);
    arp_item_t it;
    it = '{default: '0};
    it.op = op;
    it.lookup_ip = ip;
    return it;
  endfunction

  function automatic logic [31:0] pick_ip();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return $urandom;
      2: return 32'hffff_ffff;
      default: return {24'h0a0000, 8'($urandom_range(23))};
    endcase
  endfunction

  function automatic logic [47:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // random item: mostly well-formed frames and lookups over a small address pool
  function automatic arp_item_t rand_item();
    arp_item_t it;
    int sel;
    sel = $urandom_range(99);
    if (sel < 45) begin
      it = mk_frame($urandom_range(9) < 7 ? CODE_REQ : CODE_RSP, rand_mac(),
                    pick_ip(), pick_ip());
      if ($urandom_range(9) == 0) it.arp_code = 16'($urandom);
    end else if (sel < 72) begin
      it = mk_op(OP_LOOKUP, pick_ip());
    end else if (sel < 90) begin
      it = mk_op(OP_TICK, 32'd0);
    end else begin
      it = '{op: 2'($urandom), hw_type: 16'($urandom), proto_type: 16'($urandom),
             hw_len: 8'($urandom), proto_len: 8'($urandom), arp_code: 16'($urandom),
             src_mac: rand_mac(), src_ip: $urandom, dst_ip: $urandom, lookup_ip: $urandom};
      if ($urandom_range(1)) begin
        it.op = OP_FRAME;
        case ($urandom_range(3))
          0: it.hw_type = HW_ETHER;
          1: it.proto_type = PROTO_IPV4;
          2: it.hw_len = HW_SIZE;
          default: it.proto_len = PROTO_SIZE;
        endcase
      end
    end
    return it;
  endfunction

  // one item transfer; start stays high on return
  task automatic send_item(input arp_item_t it, input bit typed, input arp_result_t want);
    arp_result_t p;
    start <= 1'b1;
    in_op <= it.op; in_hw_type <= it.hw_type; in_proto_type <= it.proto_type;
    in_hw_len <= it.hw_len; in_proto_len <= it.proto_len; in_arp_code <= it.arp_code;
    in_src_mac <= it.src_mac; in_src_ip <= it.src_ip; in_dst_ip <= it.dst_ip;
    in_lookup_ip <= it.lookup_ip;
    do @(posedge clk); while (busy);
    p = arp_predict(it);
    pending_q.push_back(typed ? want : p);
    items_sent++;
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < sender_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [47:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_OWN_MAC: m_own_mac = val;
      CFG_OWN_IP: m_own_ip = val[31:0];
      CFG_SUB_BASE: m_sub_base = val[31:0];
      CFG_SUB_MASK: m_sub_mask = val[31:0];
      CFG_LIFETIME: m_lifetime = val[15:0];
      default: ;
    endcase
  endtask

  initial begin
    arp_result_t z, t;
    logic [47:0] mac_set [NumChunks];
    logic [31:0] ip_set [NumChunks], base_set [NumChunks], mask_set [NumChunks];
    logic [15:0] life_set [NumChunks];
    z = '{default: '0};

    rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_op = '0; in_hw_type = '0; in_proto_type = '0; in_hw_len = '0; in_proto_len = '0;
    in_arp_code = '0; in_src_mac = '0; in_src_ip = '0; in_dst_ip = '0; in_lookup_ip = '0;
    m_own_mac = '0; m_own_ip = '0; m_sub_base = '0; m_sub_mask = '0; m_lifetime = 16'd30;
    now_ticks = '0;
    for (int i = 0; i < CacheEntries; i++) begin
      c_ip[i] = '0; c_mac[i] = '0; c_expiry[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at reset configuration
    t = z; t.status = ST_MISS; t.send_frame = 1'b1; t.dst_mac = BCAST_MAC;
    t.code = CODE_REQ[1:0]; t.tgt_ip = 32'h0a00_0005;
    dir_rows.push_back('{mk_op(OP_LOOKUP, 32'h0a00_0005), 1'b1, t});
    dir_rows.push_back('{mk_op(OP_TICK, 32'd0), 1'b1, z});
    dir_rows.push_back('{mk_op(2'd3, 32'hffff_ffff), 1'b1, z});
    t = z; t.status = ST_BADFMT;
    dir_rows.push_back('{'{OP_FRAME, 16'h0000, PROTO_IPV4, HW_SIZE, PROTO_SIZE, CODE_REQ,
                          48'h1, 32'h1, 32'h2, 32'h0}, 1'b1, t});
    dir_rows.push_back('{'{OP_FRAME, HW_ETHER, 16'hffff, HW_SIZE, PROTO_SIZE, CODE_REQ,
                          48'h1, 32'h1, 32'h2, 32'h0}, 1'b1, t});
    dir_rows.push_back('{'{OP_FRAME, HW_ETHER, PROTO_IPV4, 8'hff, PROTO_SIZE, CODE_REQ,
                          48'h1, 32'h1, 32'h2, 32'h0}, 1'b1, t});
    dir_rows.push_back('{'{OP_FRAME, HW_ETHER, PROTO_IPV4, HW_SIZE, 8'h00, CODE_REQ,
                          48'h1, 32'h1, 32'h2, 32'h0}, 1'b1, t});
    dir_rows.push_back('{mk_frame(CODE_REQ, 48'h0200_0000_0002, 32'h0a00_0002,
                                  32'h0a00_0003), 1'b0, z});
    dir_rows.push_back('{mk_frame(CODE_REQ, 48'h0200_0000_0009, 32'h0, 32'h0a00_0004),
                         1'b0, z});
    dir_rows.push_back('{mk_frame(CODE_REQ, 48'h0200_0000_0006, 32'h0a00_0006,
                                  32'h0a00_0006), 1'b0, z});
    dir_rows.push_back('{mk_frame(CODE_RSP, 48'hffff_ffff_ffff, 32'hffff_ffff,
                                  32'h0), 1'b0, z});
    dir_rows.push_back('{mk_frame(16'hffff, 48'h0, 32'h0a00_0007, 32'hffff_ffff), 1'b0, z});
    dir_rows.push_back('{mk_frame(CODE_REQ, 48'h0200_0000_0008, 32'h0a00_0008,
                                  32'h0a00_0002), 1'b0, z});
    dir_rows.push_back('{mk_op(OP_LOOKUP, 32'h0a00_0002), 1'b0, z});
    dir_rows.push_back('{mk_op(OP_LOOKUP, 32'hffff_ffff), 1'b0, z});
    dir_rows.push_back('{mk_op(OP_LOOKUP, 32'h0), 1'b0, z});
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
    drain();

    // settings per random chunk, extremes included
    mac_set = '{48'h0211_2233_4455, 48'h0, 48'hffff_ffff_ffff, 48'h02ab_cdef_0123,
                48'h0211_2233_4455, 48'h0266_7788_99aa};
    ip_set = '{32'h0a00_0001, 32'h0, 32'hffff_ffff, 32'h0a00_0001, 32'h0a00_00fe,
               32'h0a00_0001};
    base_set = '{32'h0a00_0000, 32'h0, 32'h0a00_0005, 32'h0a00_0000, 32'h0a00_0000,
                 32'h0a00_0000};
    mask_set = '{32'hffff_ff00, 32'h0, 32'hffff_ffff, 32'hffff_fff0, 32'hffff_ff00,
                 32'hffff_ff00};
    life_set = '{16'd5, 16'd0, 16'hffff, 16'd3, 16'd1, 16'd30};

    for (int c = 0; c < NumChunks; c++) begin
      cfg_write(CFG_OWN_MAC, mac_set[c]);
      cfg_write(CFG_OWN_IP, {16'd0, ip_set[c]});
      cfg_write(CFG_SUB_BASE, {16'd0, base_set[c]});
      cfg_write(CFG_SUB_MASK, {16'd0, mask_set[c]});
      cfg_write(CFG_LIFETIME, {32'd0, life_set[c]});
      sender_pct = (c % 3 == 0) ? 17 : (c % 3 == 1) ? 63 : 0;
      for (int n = 0; n < ChunkItems; n++) begin
        send_item(rand_item(), 1'b0, z);
        // hold off until everything in flight has come back
        if (c == 0 && n == ChunkItems / 2) drain();
        else sender_gap();
      end
      drain();
    end

    repeat (30) @(posedge clk);
    $display("covered %0d items, %0d results: %0d proxy replies, %0d cache hits, %0d full-cache",
             items_sent, results_seen, replies, hits, fails_seen);
    $display("six configuration sets incl. zero and all-ones registers, lifetimes 0 to 65535");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("** arp_cache_responder: PASSED **");
    end else begin
      $display("** arp_cache_responder: FAILED **");
    end
    $finish;
  end
endmodule
